// ----- rtl/core/button_debounce_long_press_core_macros.svh -----
// ----------------------------------------------------------------------------
// button_debounce_long_press_core_macros
// Assertion helpers for the button debounce core.
// ----------------------------------------------------------------------------
`ifndef BUTTON_DEBOUNCE_LONG_PRESS_CORE_MACROS_SVH
`define BUTTON_DEBOUNCE_LONG_PRESS_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Checked at every rising edge, including while reset is high
`define BDLP_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("bdlp assertion failed");

// Checked at every rising edge outside reset
`define BDLP_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("bdlp assertion failed");

`else

`define BDLP_ASSERT_ALWAYS(lbl, clk, prop)
`define BDLP_ASSERT(lbl, clk, rst, prop)

`endif

`endif

// ----- rtl/core/bdlp_pkg.sv -----
// ----------------------------------------------------------------------------
// bdlp_pkg
// Widths, register indexes and reset values for the button debounce core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bdlp_pkg;

   localparam int TIME_WIDTH_DEFAULT = 24;

   localparam int RUN_W      = 4;
   localparam int TICK_W     = 10;
   localparam int HOLD_W     = 24;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;

   localparam logic [CSR_IDX_W-1:0] REG_DEBOUNCE_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TICK_MS        = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_PROVISION_HOLD = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_RESET_HOLD     = 2'd3;

   localparam logic [RUN_W-1:0]  DEBOUNCE_COUNT_RST = 4'd3;
   localparam logic [TICK_W-1:0] TICK_MS_RST        = 10'd10;
   localparam logic [HOLD_W-1:0] PROVISION_HOLD_RST = 24'd3000;
   localparam logic [HOLD_W-1:0] RESET_HOLD_RST     = 24'd10000;

endpackage

// ----- rtl/core/button_debounce_long_press_core.sv -----
// Results are registered: one is valid in the cycle after its transaction is accepted.
// Throughput: one tick per cycle; the single update stage and the output
// register pass a new tick every cycle while results are taken.
// Reset (synchronous, active high) sets the registers to 3, 10, 3000, 10000
// and clears the debounce state, hold time, one-shot flags and output valid.
// ----------------------------------------------------------------------------
// button_debounce_long_press_core
// Debounces an active-low button level and flags provisioning and factory
// reset holds once per press.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "button_debounce_long_press_core_macros.svh"

module button_debounce_long_press_core
   import bdlp_pkg::*;
#(
   parameter int TIME_WIDTH = TIME_WIDTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_raw_level,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_pressed,
   output logic                  rsp_provision_event,
   output logic                  rsp_factory_event,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);

   localparam int SUM_W = ((TIME_WIDTH > TICK_W) ? TIME_WIDTH : TICK_W) + 1;
   localparam int CMP_W = (TIME_WIDTH > HOLD_W) ? TIME_WIDTH : HOLD_W;
   localparam logic [TIME_WIDTH-1:0] TIME_MAX = {TIME_WIDTH{1'b1}};

   // configuration
   logic [RUN_W-1:0]  debounce_count_ff;
   logic [TICK_W-1:0] tick_ms_ff;
   logic [HOLD_W-1:0] provision_hold_ff;
   logic [HOLD_W-1:0] reset_hold_ff;

   // debounce state
   logic                  stable_ff, stable_in;
   logic                  prev_sample_ff, prev_sample_in;
   logic [RUN_W-1:0]      equal_run_ff, equal_run_in;
   logic [TIME_WIDTH-1:0] hold_ff, hold_in;
   logic                  prov_done_ff, prov_done_in;
   logic                  fact_done_ff, fact_done_in;

   // result register
   logic rsp_valid_ff;
   logic rsp_pressed_ff, rsp_prov_ff, rsp_fact_ff;
   logic prov_ev, fact_ev;

   logic             sample;
   logic             accept;
   logic [SUM_W-1:0] hold_sum;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign sample    = !req_raw_level;
   assign hold_sum  = SUM_W'(hold_ff) + SUM_W'(tick_ms_ff);

   always_comb begin
      prev_sample_in = prev_sample_ff;
      equal_run_in   = equal_run_ff;
      stable_in      = stable_ff;
      hold_in        = hold_ff;
      prov_done_in   = prov_done_ff;
      fact_done_in   = fact_done_ff;
      prov_ev        = 1'b0;
      fact_ev        = 1'b0;

      if (sample == prev_sample_ff) begin
         if (equal_run_ff < debounce_count_ff) begin
            equal_run_in = equal_run_ff + 1'b1;
         end
      end else begin
         equal_run_in   = RUN_W'(1);
         prev_sample_in = sample;
      end

      // flip the debounced state and restart the press
      if (equal_run_in >= debounce_count_ff && stable_ff != sample) begin
         stable_in    = sample;
         hold_in      = '0;
         prov_done_in = 1'b0;
         fact_done_in = 1'b0;
      end

      if (stable_in) begin
         if (stable_ff == stable_in) begin
            hold_in = (hold_sum[SUM_W-1:TIME_WIDTH] != '0) ? TIME_MAX
                                                            : TIME_WIDTH'(hold_sum);
         end else begin
            hold_in = (TICK_W > TIME_WIDTH && (SUM_W'(tick_ms_ff) > SUM_W'(TIME_MAX)))
                      ? TIME_MAX : TIME_WIDTH'(tick_ms_ff);
         end
         if (!prov_done_in && CMP_W'(hold_in) >= CMP_W'(provision_hold_ff)) begin
            prov_ev      = 1'b1;
            prov_done_in = 1'b1;
         end
         if (!fact_done_in && CMP_W'(hold_in) >= CMP_W'(reset_hold_ff)) begin
            fact_ev      = 1'b1;
            fact_done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_count_ff <= DEBOUNCE_COUNT_RST;
         tick_ms_ff        <= TICK_MS_RST;
         provision_hold_ff <= PROVISION_HOLD_RST;
         reset_hold_ff     <= RESET_HOLD_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_DEBOUNCE_COUNT: debounce_count_ff <= csr_wr_data[RUN_W-1:0];
            REG_TICK_MS:        tick_ms_ff        <= csr_wr_data[TICK_W-1:0];
            REG_PROVISION_HOLD: provision_hold_ff <= csr_wr_data[HOLD_W-1:0];
            REG_RESET_HOLD:     reset_hold_ff     <= csr_wr_data[HOLD_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stable_ff      <= 1'b0;
         prev_sample_ff <= 1'b0;
         equal_run_ff   <= '0;
         hold_ff        <= '0;
         prov_done_ff   <= 1'b0;
         fact_done_ff   <= 1'b0;
      end else if (accept) begin
         stable_ff      <= stable_in;
         prev_sample_ff <= prev_sample_in;
         equal_run_ff   <= equal_run_in;
         hold_ff        <= hold_in;
         prov_done_ff   <= prov_done_in;
         fact_done_ff   <= fact_done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // payload: load with each accepted transaction, hold otherwise
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_pressed_ff <= stable_in;
         rsp_prov_ff    <= prov_ev;
         rsp_fact_ff    <= fact_ev;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_pressed         = rsp_pressed_ff;
   assign rsp_provision_event = rsp_prov_ff;
   assign rsp_factory_event   = rsp_fact_ff;

   `BDLP_ASSERT(a_accept_gives_result, clock, reset, accept |=> rsp_valid_ff)
   `BDLP_ASSERT(a_prov_only_pressed, clock, reset, (rsp_valid_ff && rsp_prov_ff) |-> rsp_pressed_ff)
   `BDLP_ASSERT(a_fact_only_pressed, clock, reset, (rsp_valid_ff && rsp_fact_ff) |-> rsp_pressed_ff)
   `BDLP_ASSERT(a_released_no_hold, clock, reset, !stable_ff |-> (hold_ff == '0))
   `BDLP_ASSERT(a_flag_clears_on_flip, clock, reset, (!$past(reset) && $fell(prov_done_ff)) |-> (stable_ff != $past(stable_ff)))

endmodule
